// ===== hdl/im2col_pkg.sv =====
// Shared types and constants of the im2col patch expander.
// Used by the top level, the shared multiply-add unit and the grid divider.
// No dependencies.
package im2col_pkg;

    // Image store and sizing limits.
    localparam int STORE_WORDS  = 16384;
    localparam int STORE_AW     = $clog2(STORE_WORDS);
    localparam int MAX_KERNEL   = 8;
    localparam int MAX_CHANNELS = 16;

    // Datapath widths.
    localparam int MAC_W      = 24;
    localparam int MAC_BW     = 9;
    localparam int GRID_W     = 8;
    localparam int STEP_W     = 4;
    localparam int POS_W      = 12;
    localparam int KIDX_W     = 3;
    localparam int INDEX_W    = 22;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Request codes.
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_EXPAND = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_COLS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_ROWS    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COLS    = 3'd7;

    // Configuration reset values.
    localparam logic [6:0] RST_IMAGE_HEIGHT = 7'd32;
    localparam logic [6:0] RST_IMAGE_WIDTH  = 7'd32;
    localparam logic [3:0] RST_KERNEL_ROWS  = 4'd3;
    localparam logic [3:0] RST_KERNEL_COLS  = 4'd3;
    localparam logic [2:0] RST_PAD_ROWS     = 3'd1;
    localparam logic [2:0] RST_PAD_COLS     = 3'd1;
    localparam logic [3:0] RST_STEP_ROWS    = 4'd1;
    localparam logic [3:0] RST_STEP_COLS    = 4'd1;

    // One operation of the shared multiply-add unit: a*b + c.
    typedef struct packed {
        logic signed [MAC_W-1:0]  a;
        logic signed [MAC_BW-1:0] b;
        logic signed [MAC_W-1:0]  c;
    } mac_op_t;

    // Request to and status from a grid divider.
    typedef struct packed {
        logic              go;
        logic [GRID_W-1:0] dividend;
        logic [STEP_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic [GRID_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== hdl/im2col_mac.sv =====
// Shared multiply-add unit of the im2col expander, one registered a*b + c per cycle.
// Depends on im2col_pkg.
module im2col_mac import im2col_pkg::*;
(
    input  logic                    clk,
    input  mac_op_t                 op,
    output logic signed [MAC_W-1:0] q
);

    logic signed [MAC_W+MAC_BW-1:0] prod;

    assign prod = op.a * op.b;

    always_ff @(posedge clk)
    begin
        q <= prod[MAC_W-1:0] + op.c;
    end

endmodule

// ===== hdl/im2col_div.sv =====
// Bit-serial restoring divider that sizes one axis of the output grid.
// Depends on im2col_pkg; one quotient bit per cycle.
module im2col_div import im2col_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(GRID_W);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [STEP_W-1:0] rem_reg;
    logic [STEP_W-1:0] div_reg;
    logic [GRID_W-1:0] quo_reg;
    logic [STEP_W:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[GRID_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.go)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(GRID_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            rem_reg <= '0;
            div_reg <= req.divisor;
            quo_reg <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? STEP_W'(trial - {1'b0, div_reg}) : trial[STEP_W-1:0];
            quo_reg <= {quo_reg[GRID_W-2:0], fits};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hdl/im2col_patch_expander_core.sv =====
// Top level of the im2col patch expander: image store, sequencer and result stage.
// Depends on im2col_pkg, im2col_mac and im2col_div.
//
// Usage. An input beat is taken at a rising edge with start high and busy low.
// A write beat (req_type 0) stores pixel_word at pixel_address and leaves busy
// low, so writes may follow each other in every cycle. An expand beat
// (req_type 1) names a channel and an output row and column. The sequencer
// then steps through its setup states, running the shared multiply-add unit
// once per cycle to form the grid products, the first column index and the
// first store address. After that it walks the kernel, one tap per cycle and
// one store read per tap inside the image, with busy high until the walk
// ends, and the results appear on the result ports after the setup, one per
// cycle, with run_last on the final one. A position that cannot be expanded
// gives a single beat with range_error set. Configuration beats are always
// taken (cfg_ready is tied high). After reset and after every configuration
// write, busy is high while two bit-serial dividers size the output grid.
// Reset restores the register defaults; the store contents are undefined
// until written. Each result beat is shown for exactly one cycle, and the
// receiver cannot stall it.
module im2col_patch_expander_core import im2col_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  req_type,
    input  logic [13:0]           pixel_address,
    input  logic [31:0]           pixel_word,
    input  logic [3:0]            channel_sel,
    input  logic [5:0]            out_row,
    input  logic [5:0]            out_col,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  result_valid,
    output logic [INDEX_W-1:0]    column_index,
    output logic [31:0]           column_value,
    output logic                  run_last,
    output logic                  range_error
);

    // Sequencer states. The setup states are named after the product that the
    // shared unit forms in them.
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_HW     = 4'd1;
    localparam logic [3:0] ST_CHK    = 4'd2;
    localparam logic [3:0] ST_KK     = 4'd3;
    localparam logic [3:0] ST_CKK    = 4'd4;
    localparam logic [3:0] ST_ROW    = 4'd5;
    localparam logic [3:0] ST_BASE   = 4'd6;
    localparam logic [3:0] ST_HWC    = 4'd7;
    localparam logic [3:0] ST_H0     = 4'd8;
    localparam logic [3:0] ST_W0     = 4'd9;
    localparam logic [3:0] ST_RA     = 4'd10;
    localparam logic [3:0] ST_RB     = 4'd11;
    localparam logic [3:0] ST_DECIDE = 4'd12;
    localparam logic [3:0] ST_TAP    = 4'd13;

    // Configuration registers.
    logic [6:0] img_h_reg;
    logic [6:0] img_w_reg;
    logic [3:0] ker_r_reg;
    logic [3:0] ker_c_reg;
    logic [2:0] pad_r_reg;
    logic [2:0] pad_c_reg;
    logic [3:0] step_r_reg;
    logic [3:0] step_c_reg;
    logic       cfg_write;
    logic       cfg_ok;

    // Grid sizing.
    logic              grid_pending_reg;
    logic              grid_pending_next;
    logic              grid_go;
    logic              div_busy;
    logic [8:0]        n_rows;
    logic [8:0]        n_cols;
    div_req_t          rows_req;
    div_req_t          cols_req;
    div_rsp_t          rows_rsp;
    div_rsp_t          cols_rsp;
    logic [GRID_W-1:0] hcol;
    logic [GRID_W-1:0] wcol;

    // Sequencer and datapath.
    logic [3:0]              state_reg;
    logic [3:0]              state_next;
    logic                    accept;
    logic                    expand_err;
    mac_op_t                 mac_op;
    logic signed [MAC_W-1:0] mac_q;
    logic [3:0]              ch_reg;
    logic [5:0]              orow_reg;
    logic [5:0]              ocol_reg;
    logic                    chk_ok_reg;
    logic [INDEX_W-1:0]      idx_reg;
    logic [INDEX_W-1:0]      hw_reg;
    logic signed [POS_W-1:0] h_reg;
    logic signed [POS_W-1:0] w_reg;
    logic signed [POS_W-1:0] w0_reg;
    logic signed [MAC_W-1:0] rowa_reg;
    logic signed [MAC_W-1:0] addr_reg;
    logic [KIDX_W-1:0]       p_reg;
    logic [KIDX_W-1:0]       j_reg;
    logic                    h_ok;
    logic                    w_ok;
    logic                    tap_in;
    logic                    row_end;
    logic                    tap_last;

    // Image store and result stage.
    logic [31:0]         store_mem [STORE_WORDS];
    logic                wr_en;
    logic                rd_en;
    logic [31:0]         rd_data_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [INDEX_W-1:0]  out_idx_reg;
    logic                out_inrange_reg;
    logic                out_last_reg;
    logic                out_err_reg;

    //------------------------------------------------------------------
    // Configuration port. Writes are always taken.
    //------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_h_reg  <= RST_IMAGE_HEIGHT;
            img_w_reg  <= RST_IMAGE_WIDTH;
            ker_r_reg  <= RST_KERNEL_ROWS;
            ker_c_reg  <= RST_KERNEL_COLS;
            pad_r_reg  <= RST_PAD_ROWS;
            pad_c_reg  <= RST_PAD_COLS;
            step_r_reg <= RST_STEP_ROWS;
            step_c_reg <= RST_STEP_COLS;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_HEIGHT: img_h_reg  <= cfg_data;
                REG_IMAGE_WIDTH:  img_w_reg  <= cfg_data;
                REG_KERNEL_ROWS:  ker_r_reg  <= cfg_data[3:0];
                REG_KERNEL_COLS:  ker_c_reg  <= cfg_data[3:0];
                REG_PAD_ROWS:     pad_r_reg  <= cfg_data[2:0];
                REG_PAD_COLS:     pad_c_reg  <= cfg_data[2:0];
                REG_STEP_ROWS:    step_r_reg <= cfg_data[3:0];
                REG_STEP_COLS:    step_c_reg <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    // The padded image must hold at least one kernel, and every size and step
    // must lie within its range. Padding always does, given its width.
    assign cfg_ok = (img_h_reg != 7'd0) && (img_h_reg <= 7'd64) &&
                    (img_w_reg != 7'd0) && (img_w_reg <= 7'd64) &&
                    (ker_r_reg != 4'd0) && (32'(ker_r_reg) <= MAX_KERNEL) &&
                    (ker_c_reg != 4'd0) && (32'(ker_c_reg) <= MAX_KERNEL) &&
                    (step_r_reg != 4'd0) && (step_r_reg <= 4'd8) &&
                    (step_c_reg != 4'd0) && (step_c_reg <= 4'd8) &&
                    (9'(img_h_reg) + 9'({pad_r_reg, 1'b0}) >= 9'(ker_r_reg)) &&
                    (9'(img_w_reg) + 9'({pad_c_reg, 1'b0}) >= 9'(ker_c_reg));

    //------------------------------------------------------------------
    // Grid sizing. The output grid is (padded size - kernel) / step + 1 on
    // each axis. It is recomputed after reset and after every register write;
    // a bad configuration gives a meaningless grid that is never used, since
    // every expand then ends in the error beat.
    //------------------------------------------------------------------
    assign n_rows = 9'(img_h_reg) + 9'({pad_r_reg, 1'b0}) - 9'(ker_r_reg);
    assign n_cols = 9'(img_w_reg) + 9'({pad_c_reg, 1'b0}) - 9'(ker_c_reg);

    assign div_busy = rows_rsp.busy || cols_rsp.busy;
    assign grid_go  = grid_pending_reg && !div_busy && (state_reg == ST_IDLE);

    assign rows_req.go       = grid_go;
    assign rows_req.dividend = n_rows[GRID_W-1:0];
    assign rows_req.divisor  = step_r_reg;
    assign cols_req.go       = grid_go;
    assign cols_req.dividend = n_cols[GRID_W-1:0];
    assign cols_req.divisor  = step_c_reg;

    im2col_div u_rows_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rows_req),
        .rsp   (rows_rsp)
    );

    im2col_div u_cols_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cols_req),
        .rsp   (cols_rsp)
    );

    assign hcol = rows_rsp.quotient + 1'b1;
    assign wcol = cols_rsp.quotient + 1'b1;

    // A write landing while a division starts keeps the request pending, so the
    // grid is sized again from the new values.
    always_comb
    begin
        grid_pending_next = grid_pending_reg;
        if (cfg_write)
        begin
            grid_pending_next = 1'b1;
        end
        else if (grid_go)
        begin
            grid_pending_next = 1'b0;
        end
    end

    //------------------------------------------------------------------
    // Sequencer.
    //------------------------------------------------------------------
    assign busy   = (state_reg != ST_IDLE) || grid_pending_reg || div_busy;
    assign accept = start && !busy;

    assign expand_err = !cfg_ok || (32'(ch_reg) >= MAX_CHANNELS) ||
                        ({2'b00, orow_reg} >= hcol) || ({2'b00, ocol_reg} >= wcol) ||
                        !chk_ok_reg;

    // Tap bounds and kernel walk.
    assign h_ok     = !h_reg[POS_W-1] && (h_reg[POS_W-2:0] < (POS_W-1)'(img_h_reg));
    assign w_ok     = !w_reg[POS_W-1] && (w_reg[POS_W-2:0] < (POS_W-1)'(img_w_reg));
    assign tap_in   = h_ok && w_ok;
    assign row_end  = ({1'b0, j_reg} + 4'd1) == ker_c_reg;
    assign tap_last = row_end && (({1'b0, p_reg} + 4'd1) == ker_r_reg);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_EXPAND))
                begin
                    state_next = ST_HW;
                end
            end
            ST_HW:     state_next = ST_CHK;
            ST_CHK:    state_next = ST_KK;
            ST_KK:     state_next = ST_CKK;
            ST_CKK:    state_next = ST_ROW;
            ST_ROW:    state_next = ST_BASE;
            ST_BASE:   state_next = ST_HWC;
            ST_HWC:    state_next = ST_H0;
            ST_H0:     state_next = ST_W0;
            ST_W0:     state_next = ST_RA;
            ST_RA:     state_next = ST_RB;
            ST_RB:     state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                out_valid_next = expand_err;
                state_next     = expand_err ? ST_IDLE : ST_TAP;
            end
            ST_TAP:
            begin
                out_valid_next = 1'b1;
                if (tap_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Shared unit schedule. Each setup state issues one a*b + c; its result is
    // in mac_q during the following state.
    always_comb
    begin
        mac_op.a = '0;
        mac_op.b = '0;
        mac_op.c = '0;
        case (state_reg)
            ST_HW:
            begin
                mac_op.a = MAC_W'(img_h_reg);
                mac_op.b = MAC_BW'(img_w_reg);
            end
            ST_CHK:
            begin
                mac_op.a = mac_q;
                mac_op.b = MAC_BW'(5'(ch_reg) + 5'd1);
            end
            ST_KK:
            begin
                mac_op.a = MAC_W'(ker_r_reg);
                mac_op.b = MAC_BW'(ker_c_reg);
            end
            ST_CKK:
            begin
                mac_op.a = mac_q;
                mac_op.b = MAC_BW'(ch_reg);
            end
            ST_ROW:
            begin
                mac_op.a = mac_q;
                mac_op.b = MAC_BW'(hcol);
                mac_op.c = MAC_W'(orow_reg);
            end
            ST_BASE:
            begin
                mac_op.a = mac_q;
                mac_op.b = MAC_BW'(wcol);
                mac_op.c = MAC_W'(ocol_reg);
            end
            ST_HWC:
            begin
                mac_op.a = MAC_W'(hcol);
                mac_op.b = MAC_BW'(wcol);
            end
            ST_H0:
            begin
                mac_op.a = MAC_W'(orow_reg);
                mac_op.b = MAC_BW'(step_r_reg);
                mac_op.c = -MAC_W'(pad_r_reg);
            end
            ST_W0:
            begin
                mac_op.a = MAC_W'(ocol_reg);
                mac_op.b = MAC_BW'(step_c_reg);
                mac_op.c = -MAC_W'(pad_c_reg);
            end
            ST_RA:
            begin
                mac_op.a = MAC_W'(ch_reg);
                mac_op.b = MAC_BW'(img_h_reg);
                mac_op.c = MAC_W'(h_reg);
            end
            ST_RB:
            begin
                mac_op.a = mac_q;
                mac_op.b = MAC_BW'(img_w_reg);
                mac_op.c = MAC_W'(w0_reg);
            end
            default:
            begin
                mac_op.a = '0;
            end
        endcase
    end

    im2col_mac u_mac
    (
        .clk (clk),
        .op  (mac_op),
        .q   (mac_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            grid_pending_reg <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            grid_pending_reg <= grid_pending_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Datapath registers. The column index steps by hcol*wcol per tap and is
    // kept to its low bits; the store address steps by one along a kernel row
    // and by the image width from row to row.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && accept)
        begin
            ch_reg   <= channel_sel;
            orow_reg <= out_row;
            ocol_reg <= out_col;
        end
        case (state_reg)
            ST_KK:  chk_ok_reg <= mac_q <= MAC_W'(STORE_WORDS);
            ST_HWC: idx_reg    <= mac_q[INDEX_W-1:0];
            ST_H0:  hw_reg     <= mac_q[INDEX_W-1:0];
            ST_W0:  h_reg      <= mac_q[POS_W-1:0];
            ST_RA:
            begin
                w0_reg <= mac_q[POS_W-1:0];
                w_reg  <= mac_q[POS_W-1:0];
            end
            ST_DECIDE:
            begin
                rowa_reg        <= mac_q;
                addr_reg        <= mac_q;
                p_reg           <= '0;
                j_reg           <= '0;
                out_idx_reg     <= '0;
                out_inrange_reg <= 1'b0;
                out_last_reg    <= 1'b1;
                out_err_reg     <= 1'b1;
            end
            ST_TAP:
            begin
                out_idx_reg     <= idx_reg;
                out_inrange_reg <= tap_in;
                out_last_reg    <= tap_last;
                out_err_reg     <= 1'b0;
                idx_reg         <= idx_reg + hw_reg;
                if (row_end)
                begin
                    j_reg    <= '0;
                    p_reg    <= p_reg + 1'b1;
                    h_reg    <= h_reg + 1'b1;
                    w_reg    <= w0_reg;
                    rowa_reg <= rowa_reg + MAC_W'(img_w_reg);
                    addr_reg <= rowa_reg + MAC_W'(img_w_reg);
                end
                else
                begin
                    j_reg    <= j_reg + 1'b1;
                    w_reg    <= w_reg + 1'b1;
                    addr_reg <= addr_reg + 1'b1;
                end
            end
            default:
            begin
                out_err_reg <= out_err_reg;
            end
        endcase
    end

    //------------------------------------------------------------------
    // Image store. Writes come only from accepted write beats, reads only from
    // taps inside the image, which the channel check keeps below the store size.
    //------------------------------------------------------------------
    assign wr_en = accept && (req_type == REQ_WRITE) && (32'(pixel_address) < STORE_WORDS);
    assign rd_en = (state_reg == ST_TAP) && tap_in;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[STORE_AW'(pixel_address)] <= pixel_word;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[STORE_AW'(addr_reg)];
        end
    end

    //------------------------------------------------------------------
    // Result beat. Taps in the padding read as zero.
    //------------------------------------------------------------------
    assign result_valid = out_valid_reg;
    assign column_index = out_idx_reg;
    assign column_value = out_inrange_reg ? rd_data_reg : 32'd0;
    assign run_last     = out_last_reg;
    assign range_error  = out_err_reg;

`ifndef NO_ASSERTIONS
    // A result beat only ever follows a cycle of work.
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result beat without preceding work");

    // A run ends with a gap: no beat directly after the last one.
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && run_last |=> !result_valid)
        else $error("result beat directly after the end of a run");

    // The error beat is a lone, zeroed, final beat.
    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && range_error |-> run_last && (column_index == '0) &&
        (column_value == '0))
        else $error("malformed error beat");

    // The walk never runs while the grid is being sized.
    a_no_walk_while_sizing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAP) |-> !div_busy)
        else $error("kernel walk overlaps grid sizing");
`endif

endmodule

// ===== tb/tb_im2col_patch_expander_core.sv =====
// Self-checking testbench for im2col_patch_expander_core: pixel writes, patch expands, geometry.
// Depends on im2col_pkg and the im2col_patch_expander_core RTL; reads no files.
module tb_im2col_patch_expander_core;
    timeunit 1ns;
    timeprecision 1ps;

    import im2col_pkg::*;

    // Extra pause before a register write, after the block has drained.
    localparam int SETTLE_CYCLES   = 16;
    // Quiet cycles at the end, long enough to catch a stray result beat.
    localparam int TAIL_CYCLES     = 80;
    localparam int RANDOM_PHASES   = 16;
    localparam int ITEMS_PER_PHASE = 13;
    // The last few random phases run with the sender never pausing.
    localparam int QUIET_PHASES    = 3;

    // One geometry setting, fields in register index order, at register widths.
    typedef struct {
        logic [6:0] height;
        logic [6:0] width;
        logic [3:0] krows;
        logic [3:0] kcols;
        logic [2:0] prows;
        logic [2:0] pcols;
        logic [3:0] srows;
        logic [3:0] scols;
    } geometry_t;

    // One expected result beat of an expand run.
    typedef struct packed {
        logic [INDEX_W-1:0] col_index;
        logic [31:0]        col_value;
        logic               is_last;
        logic               is_error;
    } tap_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  req_type = REQ_WRITE;
    logic [13:0]           pixel_address = '0;
    logic [31:0]           pixel_word = '0;
    logic [3:0]            channel_sel = '0;
    logic [5:0]            out_row = '0;
    logic [5:0]            out_col = '0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  result_valid;
    logic [INDEX_W-1:0]    column_index;
    logic [31:0]           column_value;
    logic                  run_last;
    logic                  range_error;

    // Our own copy of the block: the geometry registers and the image store.
    // pixel_known marks entries that have been written, since the block leaves
    // unwritten entries undefined and an expand must never read one.
    geometry_t   geom;
    logic [31:0] pixel_mem [STORE_WORDS];
    bit          pixel_known [STORE_WORDS];

    // Result beats still owed by the block, oldest first.
    tap_t expected_taps[$];

    int idle_pct = 0;
    int fault_count = 0;
    int expands_sent = 0;
    int writes_sent = 0;
    int taps_seen = 0;
    int errors_seen = 0;
    int settings_applied = 0;

    im2col_patch_expander_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .pixel_address(pixel_address),
        .pixel_word   (pixel_word),
        .channel_sel  (channel_sel),
        .out_row      (out_row),
        .out_col      (out_col),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .column_index (column_index),
        .column_value (column_value),
        .run_last     (run_last),
        .range_error  (range_error)
    );

    always #5 clk = ~clk;

    // Backstop: the slowest legal run ends long before this timeout.
    initial
    begin
        #10ms;
        $display("FAIL im2col_patch_expander_core");
        $finish;
    end

    // ------------------------------------------------------------------
    // Geometry and address arithmetic of the predictor.
    // ------------------------------------------------------------------

    function automatic geometry_t reset_geometry();
        geometry_t g;
        g.height = RST_IMAGE_HEIGHT;
        g.width  = RST_IMAGE_WIDTH;
        g.krows  = RST_KERNEL_ROWS;
        g.kcols  = RST_KERNEL_COLS;
        g.prows  = RST_PAD_ROWS;
        g.pcols  = RST_PAD_COLS;
        g.srows  = RST_STEP_ROWS;
        g.scols  = RST_STEP_COLS;
        return g;
    endfunction

    // A geometry is usable when every register is in its range and the padded
    // image is at least as large as the kernel in both directions.
    function automatic bit geometry_ok(geometry_t g);
        int h = g.height;
        int w = g.width;
        int kr = g.krows;
        int kc = g.kcols;
        if (h < 1 || h > 64 || w < 1 || w > 64)
            return 1'b0;
        if (kr < 1 || kr > MAX_KERNEL || kc < 1 || kc > MAX_KERNEL)
            return 1'b0;
        if (g.srows < 1 || g.srows > 8 || g.scols < 1 || g.scols > 8)
            return 1'b0;
        return (h + 2 * int'(g.prows) >= kr) && (w + 2 * int'(g.pcols) >= kc);
    endfunction

    // Output grid of the current geometry; false when the geometry is unusable.
    function automatic bit grid_dims(output int hcol, output int wcol);
        hcol = 0;
        wcol = 0;
        if (!geometry_ok(geom))
            return 1'b0;
        hcol = (int'(geom.height) + 2 * int'(geom.prows) - int'(geom.krows))
               / int'(geom.srows) + 1;
        wcol = (int'(geom.width) + 2 * int'(geom.pcols) - int'(geom.kcols))
               / int'(geom.scols) + 1;
        return 1'b1;
    endfunction

    // Highest channel whose whole image still fits in the store.
    function automatic int channel_limit();
        int fit = STORE_WORDS / (int'(geom.height) * int'(geom.width)) - 1;
        return (fit < MAX_CHANNELS - 1) ? fit : MAX_CHANNELS - 1;
    endfunction

    function automatic bit position_ok(int ch, int row, int col,
                                       output int hcol, output int wcol);
        if (!grid_dims(hcol, wcol))
            return 1'b0;
        if (ch >= MAX_CHANNELS || row >= hcol || col >= wcol)
            return 1'b0;
        return (ch + 1) * int'(geom.height) * int'(geom.width) <= STORE_WORDS;
    endfunction

    // Store address under kernel cell (p, j); false when the tap is in the padding or beyond the store.
    function automatic bit tap_address(int ch, int row, int col, int p, int j,
                                       output int addr);
        int r = row * int'(geom.srows) - int'(geom.prows) + p;
        int c = col * int'(geom.scols) - int'(geom.pcols) + j;
        addr = 0;
        if (r < 0 || c < 0 || r >= int'(geom.height) || c >= int'(geom.width))
            return 1'b0;
        addr = (ch * int'(geom.height) + r) * int'(geom.width) + c;
        return addr < STORE_WORDS;
    endfunction

    // Queue the result beats of one expand: a single error beat when the
    // position cannot be expanded, else one beat per kernel cell in row order.
    function automatic void predict_expand(int ch, int row, int col);
        int     hcol;
        int     wcol;
        int     addr;
        int     kr;
        int     kc;
        longint idx;
        tap_t   t;
        if (!position_ok(ch, row, col, hcol, wcol))
        begin
            expected_taps.push_back('{'0, 32'h0, 1'b1, 1'b1});
            return;
        end
        kr = geom.krows;
        kc = geom.kcols;
        for (int p = 0; p < kr; p++)
        begin
            for (int j = 0; j < kc; j++)
            begin
                idx = ((longint'(ch) * kr * kc + p * kc + j) * hcol + row) * wcol + col;
                t.col_index = idx[INDEX_W-1:0];
                t.col_value = tap_address(ch, row, col, p, j, addr) ? pixel_mem[addr] : 32'h0;
                t.is_last   = (p == kr - 1) && (j == kc - 1);
                t.is_error  = 1'b0;
                expected_taps.push_back(t);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking.
    // ------------------------------------------------------------------

    function automatic void note_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
            note_fault($sformatf("%s of result beat %0d: expected %h, got %h",
                                 name, taps_seen, want, got));
    endfunction

    // Every result beat is shown for one cycle and taken at the edge that ends
    // it; values read here are the ones from before that edge.
    always @(posedge clk)
    begin
        tap_t want;
        if (rst_n && result_valid)
        begin
            taps_seen++;
            if (range_error)
                errors_seen++;
            if (expected_taps.size() == 0)
                note_fault($sformatf("result beat %0d arrived with nothing pending",
                                     taps_seen));
            else
            begin
                want = expected_taps.pop_front();
                check_field("column_index", want.col_index, column_index);
                check_field("column_value", want.col_value, column_value);
                check_field("run_last", want.is_last, run_last);
                check_field("range_error", want.is_error, range_error);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Sender idling: an idle burst before a beat, with probability idle_pct percent.
    function automatic int pick_gap();
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            return $urandom_range(19, 1);
        return 0;
    endfunction

    // Send one input beat and update the predictor when it is taken. start is
    // left high afterwards so that a following beat can go in the very next
    // cycle; wait_drain lowers it, and every geometry write follows a wait_drain.
    task automatic send_item(input logic kind, input logic [13:0] addr,
                             input logic [31:0] word, input logic [3:0] ch,
                             input logic [5:0] row, input logic [5:0] col);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        req_type      <= kind;
        pixel_address <= addr;
        pixel_word    <= word;
        channel_sel   <= ch;
        out_row       <= row;
        out_col       <= col;
        do
            @(posedge clk);
        while (busy);
        if (kind == REQ_WRITE)
        begin
            pixel_mem[addr]   = word;
            pixel_known[addr] = 1'b1;
            writes_sent++;
        end
        else
        begin
            predict_expand(ch, row, col);
            expands_sent++;
        end
    endtask

    // Expand one position. Any in-image tap that has never been written gets a
    // random pixel first, so the run never reads an undefined store entry.
    task automatic expand_at(int ch, int row, int col);
        int hcol;
        int wcol;
        int addr;
        if (position_ok(ch, row, col, hcol, wcol))
        begin
            for (int p = 0; p < int'(geom.krows); p++)
            begin
                for (int j = 0; j < int'(geom.kcols); j++)
                begin
                    if (tap_address(ch, row, col, p, j, addr) && !pixel_known[addr])
                        send_item(REQ_WRITE, addr[13:0], $urandom(), $urandom(),
                                  $urandom(), $urandom());
                end
            end
        end
        send_item(REQ_EXPAND, $urandom(), $urandom(), ch[3:0], row[5:0], col[5:0]);
    endtask

    // Stop sending, wait for every owed result beat and for busy to drop, then
    // give the block a little longer so that nothing is in flight.
    task automatic wait_drain(int extra);
        start <= 1'b0;
        while (expected_taps.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Write all eight geometry registers in back-to-back beats. The block then
    // re-sizes its output grid with busy high; the next beat waits on that.
    task automatic apply_geometry(geometry_t g);
        logic [CFG_DATA_W-1:0] value_of [8];
        value_of[REG_IMAGE_HEIGHT] = g.height;
        value_of[REG_IMAGE_WIDTH]  = g.width;
        value_of[REG_KERNEL_ROWS]  = g.krows;
        value_of[REG_KERNEL_COLS]  = g.kcols;
        value_of[REG_PAD_ROWS]     = g.prows;
        value_of[REG_PAD_COLS]     = g.pcols;
        value_of[REG_STEP_ROWS]    = g.srows;
        value_of[REG_STEP_COLS]    = g.scols;
        for (int r = 0; r < 8; r++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_data  <= value_of[r];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        geom = g;
        settings_applied++;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Break one rule of a usable geometry so that every expand must fail.
    function automatic geometry_t corrupt_geometry(geometry_t g, int flaw);
        case (flaw)
            0: g.height = 7'd0;
            1: g.width = 7'($urandom_range(127, 65));
            2: g.krows = 4'd0;
            3: g.kcols = 4'($urandom_range(15, MAX_KERNEL + 1));
            4: g.srows = 4'd0;
            5: g.scols = 4'd0;
            6: g.krows = 4'd15;
            default:
            begin
                // Kernel taller than the padded image.
                g.height = 7'd2;
                g.prows  = 3'd0;
                g.krows  = 4'd3;
            end
        endcase
        return g;
    endfunction

    // Mostly small geometries so that runs stay short, sometimes large ones up
    // to the register limits, and now and then a broken one.
    function automatic geometry_t random_geometry();
        geometry_t g;
        int        mode = $urandom_range(9);
        if (mode == 1)
        begin
            g.height = 7'($urandom_range(64, 33));
            g.width  = 7'($urandom_range(64, 33));
            g.krows  = 4'($urandom_range(MAX_KERNEL, 1));
            g.kcols  = 4'($urandom_range(MAX_KERNEL, 1));
            g.prows  = 3'($urandom_range(7));
            g.pcols  = 3'($urandom_range(7));
            g.srows  = 4'($urandom_range(8, 1));
            g.scols  = 4'($urandom_range(8, 1));
        end
        else
        begin
            g.height = 7'($urandom_range(10, 1));
            g.width  = 7'($urandom_range(10, 1));
            g.krows  = 4'($urandom_range(4, 1));
            g.kcols  = 4'($urandom_range(4, 1));
            g.prows  = 3'($urandom_range(2));
            g.pcols  = 3'($urandom_range(2));
            g.srows  = 4'($urandom_range(3, 1));
            g.scols  = 4'($urandom_range(3, 1));
        end
        if (mode == 0)
            g = corrupt_geometry(g, $urandom_range(7));
        return g;
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset geometry: extreme write beats, both padded corners of the grid
    // and positions just outside it.
    task automatic test_write_and_edges();
        send_item(REQ_WRITE, 14'd0, 32'h0000_0000, 4'd0, 6'd0, 6'd0);
        send_item(REQ_WRITE, 14'h3FFF, 32'hFFFF_FFFF, 4'hF, 6'h3F, 6'h3F);
        send_item(REQ_WRITE, 14'h2AAA, 32'h5555_AAAA, 4'h5, 6'h2A, 6'h15);
        expand_at(0, 0, 0);
        expand_at(MAX_CHANNELS - 1, 31, 31);
        expand_at(0, 32, 0);
        expand_at(2, 0, 63);
    endtask

    // Eight ways a geometry can be unusable, each followed by one expand.
    task automatic test_bad_geometry();
        geometry_t g;
        for (int flaw = 0; flaw < 8; flaw++)
        begin
            g = '{7'd8, 7'd8, 4'd3, 4'd3, 3'd1, 3'd1, 4'd1, 4'd1};
            wait_drain(SETTLE_CYCLES);
            apply_geometry(corrupt_geometry(g, flaw));
            expand_at(0, 0, 0);
        end
    endtask

    // Register extremes: the largest image, kernel, padding and stride, where
    // the fourth channel fills the store exactly; then the smallest geometry.
    task automatic test_grid_limits();
        wait_drain(SETTLE_CYCLES);
        apply_geometry('{7'd64, 7'd64, 4'd8, 4'd8, 3'd7, 3'd7, 4'd8, 4'd8});
        expand_at(3, 8, 8);
        expand_at(4, 0, 0);
        expand_at(0, 9, 0);
        wait_drain(SETTLE_CYCLES);
        apply_geometry('{7'd1, 7'd1, 4'd1, 4'd1, 3'd0, 3'd0, 4'd1, 4'd1});
        expand_at(0, 0, 0);
        expand_at(MAX_CHANNELS - 1, 0, 0);
        expand_at(0, 1, 0);
    endtask

    // Random geometries, each followed by a burst of mostly legal expands with
    // random content, some stray writes and some random positions. Each new
    // setting waits for the previous burst to drain completely.
    task automatic test_random_geometries();
        int hcol;
        int wcol;
        int roll;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_drain(SETTLE_CYCLES);
            apply_geometry(random_geometry());
            if (ph >= RANDOM_PHASES - QUIET_PHASES)
                idle_pct = 0;
            else
                idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 25 : 60);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 12)
                    send_item(REQ_WRITE, $urandom(), $urandom(), $urandom(),
                              $urandom(), $urandom());
                else if (roll < 85 && grid_dims(hcol, wcol))
                    expand_at($urandom_range(channel_limit()), $urandom_range(hcol - 1),
                              $urandom_range(wcol - 1));
                else
                    expand_at($urandom_range(MAX_CHANNELS - 1), $urandom_range(63),
                              $urandom_range(63));
            end
        end
    endtask

    initial
    begin
        geom = reset_geometry();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        idle_pct = 30;
        test_write_and_edges();
        test_bad_geometry();
        test_grid_limits();
        test_random_geometries();

        wait_drain(TAIL_CYCLES);
        $display("Ran %0d expand beats and %0d pixel write beats over %0d geometry settings.",
                 expands_sent, writes_sent, settings_applied);
        $display("Checked %0d result beats, %0d of them range errors; %0d mismatches.",
                 taps_seen, errors_seen, fault_count);
        if (fault_count == 0)
            $display("PASS im2col_patch_expander_core");
        else
            $display("FAIL im2col_patch_expander_core");
        $finish;
    end

endmodule
